// File: sv/stq_pkg.sv
// Package for the sorted timer queue.
// Holds the request and response words, list entry layout, codes and FSM states.
// No dependencies.
package stq_pkg;

   localparam int SLOT_W     = 5;
   localparam int QID_W      = 4;
   localparam int DATA_W     = 8;
   localparam int TIME_W     = 32;
   localparam int NUM_QUEUES = 16;

   localparam logic [2:0] KIND_ALLOC = 3'd0;
   localparam logic [2:0] KIND_FREE  = 3'd1;
   localparam logic [2:0] KIND_BIND  = 3'd2;
   localparam logic [2:0] KIND_START = 3'd3;
   localparam logic [2:0] KIND_TICK  = 3'd4;

   localparam logic [1:0] RES_ALLOC_OK   = 2'd0;
   localparam logic [1:0] RES_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] RES_FIRED      = 2'd2;

   localparam logic [1:0] SLOT_UNUSED  = 2'd0;
   localparam logic [1:0] SLOT_ALLOC   = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;

   typedef struct packed {
      logic [2:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [QID_W-1:0]  queue_id;
      logic [DATA_W-1:0] data;
      logic [TIME_W-1:0] timeout;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [SLOT_W-1:0] slot_res;
      logic [QID_W-1:0]  queue_id_res;
      logic [DATA_W-1:0] fired_data;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   typedef struct packed {
      logic [QID_W-1:0]  queue_id;
      logic [DATA_W-1:0] data;
   } bind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALC,
      ST_FRE,
      ST_INS,
      ST_TRD,
      ST_TCMP,
      ST_TBND,
      ST_TPUSH,
      ST_FLUSH
   } state_type;

endpackage

// File: sv/stq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the active list and the bind table. No dependencies.
module stq_ram #(
   parameter int WIDTH  = 37,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/sorted_timer_queue.sv
// Sorted timer queue: pool of one-shot timers with a deadline-ordered active list.
// Depends on stq_pkg and stq_ram.
//
// Requests arrive on req_valid/req_ready with one req_word each: alloc, free,
// bind, start or tick. Results leave on rsp_valid/rsp_ready as rsp_word; alloc
// gives one word, a tick gives one word per expired timer (last marks the end),
// the rest give none. The active list is a circular buffer in a one-port-read
// RAM, each entry holding slot and deadline; queue and data sit in a second RAM.
// Work behind each accepted request, before the next one is taken:
//   alloc: one slot status checked per cycle, up to a free slot or the last slot
//   free of a running slot: full walk of the list, one entry per cycle
//   start: walk back from the tail shifting entries up
//   bind and the rest: none; tick: head read, compare, bind read, push per expiry
// Reset empties the list and clears all slot states and the tick count. A result
// waits in the output register while the receiver stalls; the next request is
// taken meanwhile unless an alloc or a tick still has a word to hand over.
module sorted_timer_queue #(
   parameter int MAX_TIMERS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stq_pkg::rsp_type rsp_word
);
   import stq_pkg::*;

   localparam int DEPTH = (MAX_TIMERS < 32) ? MAX_TIMERS : 32;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] tick_ff;
   logic [PTR_W-1:0]  head_ff, tail_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [1:0]        status_ff [DEPTH];
   logic [PTR_W-1:0]  rp_ff, wp_ff, da_ff, alc_ff;
   logic [CNT_W-1:0]  left_ff;
   logic              pend_rd_ff, found_ff;
   entry_type         ins_ff;
   rsp_type           cur_ff, pend_ff;
   logic              pend_v_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_word_ff;

   logic              lst_we, lst_re;
   logic [PTR_W-1:0]  lst_wa, lst_ra;
   entry_type         lst_wd, lst_rd;
   logic              bnd_we, bnd_re;
   logic [PTR_W-1:0]  bnd_wa, bnd_ra;
   bind_type          bnd_wd, bnd_rd;
   logic              push;
   rsp_type           push_word;

   logic              req_fire, slot_ok, start_ok, out_free;
   logic [PTR_W-1:0]  req_slot, stat_idx;
   logic [1:0]        stat_rd;
   logic              ins_shift, ins_done, fre_done, fire, alc_hit, alc_end;

   stq_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_list (
      .clock (clock),
      .we    (lst_we),
      .waddr (lst_wa),
      .wdata (lst_wd),
      .re    (lst_re),
      .raddr (lst_ra),
      .rdata (lst_rd)
   );

   stq_ram #(.WIDTH($bits(bind_type)), .DEPTH(DEPTH)) u_bind (
      .clock (clock),
      .we    (bnd_we),
      .waddr (bnd_wa),
      .wdata (bnd_wd),
      .re    (bnd_re),
      .raddr (bnd_ra),
      .rdata (bnd_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign req_slot  = req_word.slot[PTR_W-1:0];
   assign slot_ok   = (32'(req_word.slot) < DEPTH);
   assign stat_idx  = (state_ff == ST_ALC) ? alc_ff : req_slot;
   assign stat_rd   = status_ff[stat_idx];
   assign start_ok  = slot_ok && (stat_rd == SLOT_ALLOC) && (count_ff < CNT_W'(DEPTH));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ins_shift = pend_rd_ff && (lst_rd.deadline >= ins_ff.deadline);
   assign ins_done  = (pend_rd_ff && !ins_shift) || (!pend_rd_ff && (left_ff == '0));
   assign fre_done  = !pend_rd_ff && (left_ff == '0);
   assign fire      = (lst_rd.deadline <= tick_ff);
   assign alc_hit   = (stat_rd == SLOT_UNUSED);
   assign alc_end   = (alc_ff == PTR_W'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_word.kind)
                  KIND_ALLOC: state_in = ST_ALC;
                  KIND_FREE:
                     state_in = (slot_ok && stat_rd == SLOT_RUNNING) ? ST_FRE : ST_IDLE;
                  KIND_START: state_in = start_ok ? ST_INS : ST_IDLE;
                  KIND_TICK:  state_in = ST_TRD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ALC:   if (alc_hit || alc_end) state_in = ST_FLUSH;
         ST_FRE:   if (fre_done) state_in = ST_IDLE;
         ST_INS:   if (ins_done) state_in = ST_IDLE;
         ST_TRD:   state_in = (count_ff == '0) ? ST_FLUSH : ST_TCMP;
         ST_TCMP:  state_in = fire ? ST_TBND : ST_FLUSH;
         ST_TBND:  state_in = ST_TPUSH;
         ST_TPUSH: if (!pend_v_ff || out_free) state_in = ST_TRD;
         ST_FLUSH: if (!pend_v_ff || out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lst_we    = 1'b0;
      lst_wa    = wp_ff;
      lst_wd    = ins_ff;
      lst_re    = 1'b0;
      lst_ra    = rp_ff;
      bnd_we    = 1'b0;
      bnd_wa    = req_slot;
      bnd_wd    = '{queue_id: req_word.queue_id, data: req_word.data};
      bnd_re    = 1'b0;
      bnd_ra    = lst_rd.slot[PTR_W-1:0];
      push      = 1'b0;
      push_word = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            bnd_we = req_fire && (req_word.kind == KIND_BIND) && slot_ok
                     && (32'(req_word.queue_id) < NUM_QUEUES);
         end
         ST_FRE: begin
            lst_re = (left_ff != '0);
            lst_ra = rp_ff;
            lst_we = pend_rd_ff && found_ff;
            lst_wa = ptr_dec(da_ff);
            lst_wd = lst_rd;
         end
         ST_INS: begin
            lst_re = (left_ff != '0) && (!pend_rd_ff || ins_shift);
            lst_ra = ptr_dec(rp_ff);
            lst_we = ins_shift || ins_done;
            lst_wa = wp_ff;
            lst_wd = ins_shift ? lst_rd : ins_ff;
         end
         ST_TRD: begin
            lst_re = (count_ff != '0);
            lst_ra = head_ff;
         end
         ST_TCMP: begin
            bnd_re = fire;
         end
         ST_TPUSH: begin
            push           = pend_v_ff && out_free;
            push_word.last = 1'b0;
         end
         ST_FLUSH: begin
            push           = pend_v_ff && out_free;
            push_word.last = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_v_ff    <= 1'b0;
         pend_rd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            status_ff[i] <= SLOT_UNUSED;
         end
      end else begin
         state_ff <= state_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= push_word;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_word.kind)
                     KIND_ALLOC: alc_ff <= '0;
                     KIND_FREE: begin
                        if (slot_ok) begin
                           status_ff[req_slot] <= SLOT_UNUSED;
                        end
                        rp_ff       <= head_ff;
                        left_ff     <= count_ff;
                        pend_rd_ff  <= 1'b0;
                        found_ff    <= 1'b0;
                        ins_ff.slot <= req_word.slot;
                     end
                     KIND_START: begin
                        if (start_ok) begin
                           status_ff[req_slot] <= SLOT_RUNNING;
                        end
                        ins_ff.slot     <= req_word.slot;
                        ins_ff.deadline <= tick_ff + req_word.timeout;
                        wp_ff           <= tail_ff;
                        rp_ff           <= tail_ff;
                        left_ff         <= count_ff;
                        pend_rd_ff      <= 1'b0;
                     end
                     KIND_TICK: tick_ff <= tick_ff + 1'b1;
                     default: ;
                  endcase
               end
            end
            ST_ALC: begin
               if (alc_hit) begin
                  status_ff[alc_ff] <= SLOT_ALLOC;
                  pend_ff <= '{result_kind: RES_ALLOC_OK, slot_res: SLOT_W'(alc_ff),
                               queue_id_res: '0, fired_data: '0, last: 1'b1};
                  pend_v_ff <= 1'b1;
               end else if (alc_end) begin
                  pend_ff <= '{result_kind: RES_ALLOC_FAIL, slot_res: '0,
                               queue_id_res: '0, fired_data: '0, last: 1'b1};
                  pend_v_ff <= 1'b1;
               end else begin
                  alc_ff <= alc_ff + 1'b1;
               end
            end
            ST_FRE: begin
               if (pend_rd_ff && lst_rd.slot == ins_ff.slot) begin
                  found_ff <= 1'b1;
               end
               if (left_ff != '0) begin
                  da_ff      <= rp_ff;
                  rp_ff      <= ptr_inc(rp_ff);
                  left_ff    <= left_ff - 1'b1;
                  pend_rd_ff <= 1'b1;
               end else begin
                  pend_rd_ff <= 1'b0;
               end
               if (fre_done) begin
                  count_ff <= count_ff - 1'b1;
                  tail_ff  <= ptr_dec(tail_ff);
               end
            end
            ST_INS: begin
               if (lst_re) begin
                  rp_ff      <= ptr_dec(rp_ff);
                  left_ff    <= left_ff - 1'b1;
                  pend_rd_ff <= 1'b1;
               end else begin
                  pend_rd_ff <= 1'b0;
               end
               if (ins_shift) begin
                  wp_ff <= rp_ff;
               end
               if (ins_done) begin
                  count_ff <= count_ff + 1'b1;
                  tail_ff  <= ptr_inc(tail_ff);
               end
            end
            ST_TCMP: begin
               if (fire) begin
                  head_ff  <= ptr_inc(head_ff);
                  count_ff <= count_ff - 1'b1;
                  status_ff[lst_rd.slot[PTR_W-1:0]] <= SLOT_ALLOC;
                  cur_ff.slot_res <= lst_rd.slot;
               end
            end
            ST_TBND: begin
               cur_ff.result_kind  <= RES_FIRED;
               cur_ff.queue_id_res <= bnd_rd.queue_id;
               cur_ff.fired_data   <= bnd_rd.data;
               cur_ff.last         <= 1'b0;
            end
            ST_TPUSH: begin
               if (!pend_v_ff || out_free) begin
                  pend_ff   <= cur_ff;
                  pend_v_ff <= 1'b1;
               end
            end
            ST_FLUSH: begin
               if (pend_v_ff && out_free) begin
                  pend_v_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty list with head and tail apart");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |-> (count_ff < CNT_W'(DEPTH)))
      else $error("insert into a full list");

   a_fire_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TCMP && fire)
      |-> (status_ff[lst_rd.slot[PTR_W-1:0]] == SLOT_RUNNING))
      else $error("expired entry is not a running slot");

   a_unlink_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRE && fre_done) |-> found_ff)
      else $error("freed slot missing from the active list");
`endif

endmodule

// File: bench/stq_checker.sv
// Checker for the sorted timer queue: watches the request and response channels,
// predicts response words from its own timer pool model and compares them.
// Depends on stq_pkg.
module stq_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  stq_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  stq_pkg::rsp_type rsp_word,
   output int               fail_count,
   output int               pending
);
   import stq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 32;

   logic [31:0] now_ticks;
   logic [4:0]  run_list[$];
   logic [1:0]  status[POOL];
   logic [31:0] deadline[POOL];
   logic [7:0]  bound_data[POOL];
   logic [3:0]  bound_queue[POOL];
   rsp_type     due_words[$];

   assign pending = due_words.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic rsp_type mk(input logic [1:0] k, input logic [4:0] s,
                                  input logic [3:0] q, input logic [7:0] d,
                                  input logic l);
      rsp_type r;
      r.result_kind = k; r.slot_res = s; r.queue_id_res = q;
      r.fired_data = d; r.last = l;
      return r;
   endfunction

   task automatic predict_word(input req_type w);
      int i, n;
      logic [4:0] t;
      bit found;
      found = 0;
      case (w.kind)
         KIND_ALLOC: begin
            for (i = 0; i < POOL && !found; i++)
               if (status[i] == SLOT_UNUSED) begin
                  status[i] = SLOT_ALLOC;
                  due_words.push_back(mk(RES_ALLOC_OK, 5'(i), '0, '0, 1'b1));
                  found = 1;
               end
            if (!found) due_words.push_back(mk(RES_ALLOC_FAIL, '0, '0, '0, 1'b1));
         end
         KIND_FREE: begin
            if (status[w.slot] == SLOT_RUNNING)
               for (i = 0; i < run_list.size(); i++)
                  if (run_list[i] == w.slot) begin
                     run_list.delete(i);
                     break;
                  end
            status[w.slot] = SLOT_UNUSED;
         end
         KIND_BIND: begin
            bound_queue[w.slot] = w.queue_id;
            bound_data[w.slot] = w.data;
         end
         KIND_START: begin
            if (status[w.slot] == SLOT_ALLOC && run_list.size() < POOL) begin
               deadline[w.slot] = now_ticks + w.timeout;
               status[w.slot] = SLOT_RUNNING;
               for (i = 0; i < run_list.size(); i++)
                  if (deadline[run_list[i]] >= deadline[w.slot]) break;
               run_list.insert(i, w.slot);
            end
         end
         KIND_TICK: begin
            now_ticks++;
            n = 0;
            while (run_list.size() > 0 && deadline[run_list[0]] <= now_ticks) begin
               t = run_list.pop_front();
               status[t] = SLOT_ALLOC;
               due_words.push_back(mk(RES_FIRED, t, bound_queue[t], bound_data[t], 1'b0));
               n++;
            end
            if (n > 0) due_words[due_words.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   initial begin
      fail_count = 0;
      now_ticks = '0;
      for (int i = 0; i < POOL; i++) begin
         status[i] = SLOT_UNUSED;
         deadline[i] = '0; bound_data[i] = '0; bound_queue[i] = '0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0)
               report($sformatf("unexpected word %h", rsp_word));
            else begin
               e = due_words.pop_front();
               if (rsp_word.result_kind !== e.result_kind)
                  report($sformatf("result_kind %0d exp %0d", rsp_word.result_kind,
                                   e.result_kind));
               if (rsp_word.slot_res !== e.slot_res)
                  report($sformatf("slot_res %0d exp %0d", rsp_word.slot_res, e.slot_res));
               if (rsp_word.queue_id_res !== e.queue_id_res)
                  report($sformatf("queue_id_res %0d exp %0d", rsp_word.queue_id_res,
                                   e.queue_id_res));
               if (rsp_word.fired_data !== e.fired_data)
                  report($sformatf("fired_data %0d exp %0d", rsp_word.fired_data,
                                   e.fired_data));
               if (rsp_word.last !== e.last)
                  report($sformatf("last %0d exp %0d", rsp_word.last, e.last));
            end
         end
         if (req_valid && req_ready) predict_word(req_word);
      end
   end
endmodule

// File: bench/testbench.sv
// Top of the sorted timer queue bench: clock, reset, request stimulus, response
// stalls and verdict. Depends on stq_pkg, sorted_timer_queue and stq_checker.
module testbench;
   import stq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 2000000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_word;
   int      fail_count;
   int      pending;
   int      cycles = 0;
   bit      stall_on = 1;
   bit      bound[32];
   int      sent = 0;

   always #5 clock = ~clock;

   sorted_timer_queue u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   stq_checker u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("** sorted_timer_queue: FAILED **");
         $finish;
      end
   end

   // receiver stalls in its own rhythm, with quiet stretches
   always @(negedge clock) begin
      if ((cycles % 500) == 0) stall_on <= ($urandom_range(0, 2) != 0);
      rsp_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   task automatic send(input logic [2:0] k, input logic [4:0] s,
                       input logic [3:0] q, input logic [7:0] d, input logic [31:0] t);
      req_word <= '{kind: k, slot: s, queue_id: q, data: d, timeout: t};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (k == KIND_BIND || k == KIND_ALLOC) bound[s] = 1;
      sent++;
   endtask

   task automatic gap();
      int n;
      n = $urandom_range(0, 3);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic rand_word();
      int r;
      logic [4:0] s;
      logic [31:0] t;
      r = $urandom_range(0, 99);
      s = 5'($urandom_range(0, 31));
      if (r < 3) begin
         send(3'($urandom_range(5, 7)), 5'($urandom), 4'($urandom), 8'($urandom),
              $urandom);
         sent--;
      end else if (r < 20) send(KIND_ALLOC, '0, '0, '0, '0);
      else if (r < 30) send(KIND_FREE, s, '0, '0, '0);
      else if (r < 45) send(KIND_BIND, s, 4'($urandom), 8'($urandom), '0);
      else if (r < 65) begin
         case ($urandom_range(0, 9))
            0: t = $urandom;
            1: t = 32'hffffffff - $urandom_range(0, 3);
            default: t = $urandom_range(0, 12);
         endcase
         if (bound[s]) send(KIND_START, s, 4'($urandom), 8'($urandom), t);
         else send(KIND_BIND, s, 4'($urandom), 8'($urandom), '0);
      end else send(KIND_TICK, 5'($urandom), 4'($urandom), 8'($urandom), $urandom);
   endtask

   initial begin
      // bind everything once so that no unbound slot can fire
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < 32; i++) begin
         send(KIND_BIND, 5'(i), i[3:0], 8'(i * 7), '0);
         gap();
      end
      send(KIND_TICK, '0, '0, '0, '0);
      send(KIND_START, 5'd3, '0, '0, 32'd5);
      send(KIND_FREE, 5'd3, '0, '0, '0);
      for (int i = 0; i < 33; i++) send(KIND_ALLOC, '0, '0, '0, '0);
      send(KIND_BIND, 5'd0, 4'hf, 8'hff, 32'hffffffff);
      send(KIND_START, 5'd0, '0, '0, 32'hffffffff);
      send(KIND_START, 5'd0, '0, '0, 32'd1);
      send(KIND_START, 5'd1, '0, '0, 32'd0);
      send(KIND_START, 5'd2, '0, '0, 32'd2);
      send(KIND_START, 5'd4, '0, '0, 32'd2);
      send(KIND_FREE, 5'd4, '0, '0, '0);
      send(KIND_FREE, 5'd4, '0, '0, '0);
      send(3'd5, 5'h1f, 4'hf, 8'hff, 32'hffffffff);
      send(3'd7, '0, '0, '0, '0);
      repeat (3) send(KIND_TICK, '0, '0, '0, '0);
      for (int i = 0; i < 6; i++) send(KIND_FREE, 5'(i), '0, '0, '0);
      while (sent < 300) begin
         repeat ($urandom_range(1, 12)) rand_word();
         gap();
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("** sorted_timer_queue: PASSED **");
      else $display("** sorted_timer_queue: FAILED **");
      $finish;
   end
endmodule

// File: sorted_timer_queue.f
sv/stq_pkg.sv
sv/stq_ram.sv
sv/sorted_timer_queue.sv
bench/stq_checker.sv
bench/testbench.sv
